// ===== rtl/mwo_pkg.sv =====
// Shared types and constants for the multi-waveform oscillator
`default_nettype none

package mwo_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_PHASE_BITS       = 32;

    // Configuration port sizes
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Full-scale sample magnitude, also the reset amplitude
    localparam logic [14:0] A_PEAK = 15'd32767;

    // Reset value of the noise seed and of the noise register
    localparam logic [31:0] NOISE_RESET = 32'd1;

    // Waveform select codes; the remaining codes output silence
    typedef enum logic [2:0] {
        MODE_SINE     = 3'd0,
        MODE_SQUARE   = 3'd1,
        MODE_TRIANGLE = 3'd2,
        MODE_SAWTOOTH = 3'd3,
        MODE_NOISE    = 3'd4
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE       = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_AMPLITUDE  = 2'd2,
        CFG_NOISE_SEED = 2'd3
    } cfg_index_t;

    // Per-stage load enables of the sample pipeline
    typedef struct packed {
        logic take;
        logic s2;
        logic s3;
        logic s4;
        logic out;
    } stage_en_t;

    // Per-sample data leaving the phase stage
    typedef struct packed {
        logic [1:0]  quad;
        logic        peak;
        logic [15:0] saw_top;
        logic [15:0] noise;
    } tap_t;

endpackage

`default_nettype wire

// ===== rtl/mwo_phase_gen.sv =====
// Phase accumulator, noise LFSR and sine table address generation
`default_nettype none

module mwo_phase_gen #(
    parameter int PHASE_BITS = mwo_pkg::DEF_PHASE_BITS,
    parameter int ADDR_W     = 10
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  take,
    input  wire                  restart,
    input  wire [2:0]            mode,
    input  wire [31:0]           phase_step,
    input  wire [31:0]           noise_seed,
    output logic [ADDR_W-1:0]    rom_addr,
    output mwo_pkg::tap_t        tap
);

    localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
    localparam int          LFSR_STEPS = 16;

    logic [PHASE_BITS-1:0]    phase_reg;
    logic [PHASE_BITS-1:0]    phase_next;
    logic [PHASE_BITS-1:0]    phase_cur;
    logic [PHASE_BITS-1:0]    phase_dbl;
    logic [PHASE_BITS+31:0]   phase_ext;
    logic [31:0]              top32;
    logic [31:0]              lfsr_reg;
    logic [31:0]              lfsr_next;
    logic [31:0]              lfsr_cur;
    logic [1:0]               quad;
    logic [ADDR_W-1:0]        off;
    logic [ADDR_W-1:0]        rom_addr_reg;
    logic [ADDR_W-1:0]        rom_addr_next;
    mwo_pkg::tap_t            tap_reg;
    mwo_pkg::tap_t            tap_next;

    // Galois LFSR, shifting right, advanced one output word per sample
    // (a fixed XOR network once unrolled)
    function automatic logic [31:0] lfsr_advance(input logic [31:0] r);
        logic [31:0] v;
        v = r;
        for (int i = 0; i < LFSR_STEPS; i++)
        begin
            v = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
        end
        return v;
    endfunction

    // Restart handling, accumulator add and table address
    always_comb
    begin
        phase_cur  = restart ? '0 : phase_reg;
        lfsr_cur   = restart ? ((noise_seed == '0) ? mwo_pkg::NOISE_RESET : noise_seed)
                             : lfsr_reg;
        lfsr_next  = lfsr_advance(lfsr_cur);
        phase_next = phase_cur + PHASE_BITS'(phase_step);
        phase_dbl  = phase_cur << 1;

        // top 32 phase bits, zero filled below a narrow accumulator
        phase_ext  = {phase_cur, 32'b0};
        top32      = phase_ext[PHASE_BITS+31 -: 32];
        quad       = top32[31:30];
        off        = top32[29 -: ADDR_W];

        // odd quadrants run the quarter wave backwards
        rom_addr_next = quad[0] ? (~off + ADDR_W'(1)) : off;

        tap_next.quad    = quad;
        tap_next.peak    = quad[0] && (off == '0);
        tap_next.saw_top = (mode == mwo_pkg::MODE_TRIANGLE) ? phase_dbl[PHASE_BITS-1 -: 16]
                                                            : phase_cur[PHASE_BITS-1 -: 16];
        tap_next.noise   = lfsr_next[15:0];
    end

    // Oscillator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            lfsr_reg  <= mwo_pkg::NOISE_RESET;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            lfsr_reg  <= lfsr_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rom_addr_reg <= rom_addr_next;
            tap_reg      <= tap_next;
        end
    end

    assign rom_addr = rom_addr_reg;
    assign tap      = tap_reg;

endmodule

`default_nettype wire

// ===== rtl/mwo_sine_rom.sv =====
// Quarter-wave sine table with registered read
`default_nettype none

module mwo_sine_rom #(
    parameter  int DEPTH  = mwo_pkg::DEF_SINE_TABLE_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire                 clk,
    input  wire                 en,
    input  wire [ADDR_W-1:0]    addr,
    output logic [14:0]         data
);

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [14:0] rom_array_t [DEPTH];

    logic [14:0] data_reg;

    // Entry k = 32767*sin(pi/2*k/DEPTH), Q30 Taylor series to x^17, rounded
    function automatic logic [14:0] table_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        x    = (64'(k) * HALF_PI_Q30) / DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 272;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (64'(sum) * 64'(mwo_pkg::A_PEAK) + (64'd1 << 29)) >> 30;
        if (v > 64'(mwo_pkg::A_PEAK))
        begin
            v = 64'(mwo_pkg::A_PEAK);
        end
        return v[14:0];
    endfunction

    function automatic rom_array_t build_table();
        rom_array_t t;
        for (int k = 0; k < DEPTH; k++)
        begin
            t[k] = table_entry(k);
        end
        return t;
    endfunction

    localparam rom_array_t SINE_ROM = build_table();

    // Synchronous read, held while the next stage stalls
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= SINE_ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/mwo_shaper.sv =====
// Amplitude scaling and waveform selection stages
`default_nettype none

module mwo_shaper (
    input  wire                    clk,
    input  wire mwo_pkg::stage_en_t en,
    input  wire mwo_pkg::tap_t     tap,
    input  wire [14:0]             rom_data,
    input  wire [2:0]              mode,
    input  wire [14:0]             amplitude,
    output logic signed [15:0]     sample
);

    mwo_pkg::tap_t      tap2_reg;

    logic [14:0]        t_val;
    logic [15:0]        saw_abs;
    logic [29:0]        sine_prod_reg;
    logic [29:0]        sine_prod_next;
    logic [29:0]        saw_prod_reg;
    logic [29:0]        saw_prod_next;
    logic               sine_neg3_reg;
    logic               saw_neg3_reg;
    logic [15:0]        noise3_reg;

    logic [15:0]        sine_q;
    logic [15:0]        saw_q;
    logic [14:0]        sine_mag_reg;
    logic [15:0]        saw_mag_reg;
    logic               sine_neg4_reg;
    logic               saw_neg4_reg;
    logic [15:0]        noise4_reg;

    logic               sine_pos;
    logic               sine_neg;
    logic               saw_pos;
    logic               saw_neg;
    logic signed [16:0] sine_val;
    logic signed [16:0] saw_val;
    logic signed [16:0] tri_val;
    logic signed [16:0] tri_sat;
    logic signed [16:0] amp_val;
    logic signed [16:0] amp_neg;
    logic signed [15:0] sample_reg;
    logic signed [15:0] sample_next;

    // p / 32767 for p < 2^30: p = q0*32767 + (q0 + lo), remainder below 3*32767
    function automatic logic [15:0] div_peak(input logic [29:0] p);
        logic [14:0] q0;
        logic [16:0] r;
        logic [15:0] q;
        q0 = p[29:15];
        r  = {2'b0, p[14:0]} + {2'b0, q0};
        q  = {1'b0, q0};
        if (r >= {2'b0, mwo_pkg::A_PEAK})
        begin
            q = q + 16'd1;
        end
        if (r >= {1'b0, mwo_pkg::A_PEAK, 1'b0})
        begin
            q = q + 16'd1;
        end
        return q;
    endfunction

    // Stage 2: align tap data with the table read
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            tap2_reg <= tap;
        end
    end

    // Stage 3: amplitude products
    always_comb
    begin
        t_val          = tap2_reg.peak ? mwo_pkg::A_PEAK : rom_data;
        saw_abs        = tap2_reg.saw_top[15] ? (~tap2_reg.saw_top + 16'd1) : tap2_reg.saw_top;
        sine_prod_next = {15'b0, amplitude} * {15'b0, t_val};
        saw_prod_next  = {14'b0, saw_abs} * {15'b0, amplitude};
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            sine_prod_reg <= sine_prod_next;
            saw_prod_reg  <= saw_prod_next;
            sine_neg3_reg <= tap2_reg.quad[1];
            saw_neg3_reg  <= tap2_reg.saw_top[15];
            noise3_reg    <= tap2_reg.noise;
        end
    end

    // Stage 4: scale back by full scale, truncating
    assign sine_q = div_peak(sine_prod_reg);
    assign saw_q  = div_peak(saw_prod_reg);

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            sine_mag_reg  <= sine_q[14:0];
            saw_mag_reg   <= saw_q;
            sine_neg4_reg <= sine_neg3_reg;
            saw_neg4_reg  <= saw_neg3_reg;
            noise4_reg    <= noise3_reg;
        end
    end

    // Output stage: signs, triangle fold and mode select
    always_comb
    begin
        sine_pos = (sine_mag_reg != '0) && !sine_neg4_reg;
        sine_neg = (sine_mag_reg != '0) && sine_neg4_reg;
        saw_pos  = (saw_mag_reg != '0) && !saw_neg4_reg;
        saw_neg  = (saw_mag_reg != '0) && saw_neg4_reg;
        sine_val = sine_neg4_reg ? -{2'b0, sine_mag_reg} : {2'b0, sine_mag_reg};
        saw_val  = saw_neg4_reg ? -{1'b0, saw_mag_reg} : {1'b0, saw_mag_reg};
        tri_val  = ((sine_neg && saw_pos) || (sine_pos && saw_neg)) ? -saw_val : saw_val;
        // folding the most negative saw value saturates
        tri_sat  = (tri_val > 17'sd32767) ? 17'sd32767 : tri_val;
        amp_val  = {2'b0, amplitude};
        amp_neg  = -amp_val;

        case (mode)
            mwo_pkg::MODE_SINE:     sample_next = sine_val[15:0];
            mwo_pkg::MODE_SQUARE:   sample_next = sine_pos ? amp_val[15:0] : amp_neg[15:0];
            mwo_pkg::MODE_TRIANGLE: sample_next = tri_sat[15:0];
            mwo_pkg::MODE_SAWTOOTH: sample_next = saw_val[15:0];
            mwo_pkg::MODE_NOISE:    sample_next = noise4_reg;
            default:                sample_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.out)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

// ===== rtl/multi_waveform_oscillator.sv =====
// Pipeline: phase stage, stages 2, 3 and 4, then the output register.
// Throughput: one tick per cycle unless out_ready stalls a full pipeline; phase/LFSR
// update, registered sine read, 15x15/16x15 multiplies and /32767 step are pipelined.
// Back-pressure collapses bubbles, so a tick is taken while a sample waits.
// Reset: config to defaults (sine, step 0, amplitude 32767, seed 1), phase 0,
// LFSR 1, pipeline empty. The sine table is a constant ROM and needs no clearing.
`default_nettype none

module multi_waveform_oscillator #(
    parameter int SINE_TABLE_DEPTH = mwo_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = mwo_pkg::DEF_PHASE_BITS
) (
    input  wire                             clk,
    input  wire                             rst_n,
    // tick channel
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire                             restart,
    // sample channel
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic signed [15:0]              sample,
    // configuration
    input  wire                             cfg_write,
    input  wire [mwo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [mwo_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);

    logic [2:0]             mode_reg;
    logic [31:0]            step_reg;
    logic [14:0]            amp_reg;
    logic [31:0]            seed_reg;

    logic                   s1_valid_reg;
    logic                   s2_valid_reg;
    logic                   s3_valid_reg;
    logic                   s4_valid_reg;
    logic                   out_valid_reg;
    mwo_pkg::stage_en_t     en;

    logic [ADDR_W-1:0]      rom_addr;
    logic [14:0]            rom_data;
    mwo_pkg::tap_t          tap;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mwo_pkg::MODE_SINE;
            step_reg <= '0;
            amp_reg  <= mwo_pkg::A_PEAK;
            seed_reg <= mwo_pkg::NOISE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mwo_pkg::CFG_MODE:       mode_reg <= cfg_data[2:0];
                mwo_pkg::CFG_PHASE_STEP: step_reg <= cfg_data[31:0];
                mwo_pkg::CFG_AMPLITUDE:  amp_reg  <= cfg_data[14:0];
                mwo_pkg::CFG_NOISE_SEED: seed_reg <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor loads
    always_comb
    begin
        en.out   = !out_valid_reg || out_ready;
        en.s4    = !s4_valid_reg || en.out;
        en.s3    = !s3_valid_reg || en.s4;
        en.s2    = !s2_valid_reg || en.s3;
        in_ready = !s1_valid_reg || en.s2;
        en.take  = in_valid && in_ready;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en.s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en.s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en.s4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en.out)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

    mwo_phase_gen #(
        .PHASE_BITS (PHASE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_phase_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (en.take),
        .restart    (restart),
        .mode       (mode_reg),
        .phase_step (step_reg),
        .noise_seed (seed_reg),
        .rom_addr   (rom_addr),
        .tap        (tap)
    );

    mwo_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk  (clk),
        .en   (en.s2),
        .addr (rom_addr),
        .data (rom_data)
    );

    mwo_shaper u_shaper (
        .clk       (clk),
        .en        (en),
        .tap       (tap),
        .rom_data  (rom_data),
        .mode      (mode_reg),
        .amplitude (amp_reg),
        .sample    (sample)
    );

    // Checks
    logic signed [15:0] amp_pos;
    logic signed [15:0] amp_neg;

    assign amp_pos = signed'({1'b0, amp_reg});
    assign amp_neg = -amp_pos;

    a_square_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (mode_reg == mwo_pkg::MODE_SQUARE))
        |-> ((sample == amp_pos) || (sample == amp_neg)))
        else $error("square sample is not at plus or minus amplitude");

    a_sine_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (mode_reg == mwo_pkg::MODE_SINE))
        |-> ((sample >= amp_neg) && (sample <= amp_pos)))
        else $error("sine sample exceeds amplitude");

    a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (mode_reg > mwo_pkg::MODE_NOISE)) |-> (sample == '0))
        else $error("unused mode produced a nonzero sample");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
         && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("tick accepted while every stage is full and stalled");

endmodule

`default_nettype wire

// ===== sim/tb_multi_waveform_oscillator.sv =====
// Testbench for the multi-waveform oscillator: directed and random ticks checked by a predictor
`timescale 1ns / 1ps

module tb_multi_waveform_oscillator;

    localparam int          PEAK       = int'(mwo_pkg::A_PEAK);
    localparam logic [31:0] NOISE_TAPS = 32'h8020_0003;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int          ROM_DEPTH  = 1024;
    localparam int          LONG_HOLD  = 300;
    localparam int          DRAIN_GAP  = 10;

    // DUT connections
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic                   restart   = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic signed [15:0]     sample;
    logic                   cfg_write = 1'b0;
    mwo_pkg::cfg_index_t    cfg_index = mwo_pkg::CFG_MODE;
    logic [31:0]            cfg_data  = '0;

    // Predictor state and register shadow
    logic [14:0]        quarter_wave [0:ROM_DEPTH-1];
    logic [31:0]        osc_phase;
    logic [31:0]        noise_lfsr;
    logic [2:0]         cfg_mode;
    logic [31:0]        cfg_step;
    logic [14:0]        cfg_amp;
    logic [31:0]        cfg_seed;

    // Expected samples, oldest first
    logic signed [15:0] pending_samples [$];
    logic signed [15:0] want_sample;
    int                 mismatch_count = 0;

    // Traffic shaping
    bit                 src_idle_en  = 1'b0;
    bit                 sink_idle_en = 1'b0;
    int                 stall_burst_id = 0;
    int                 burst_served   = 0;
    int                 hold_left      = 0;

    multi_waveform_oscillator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Quarter-wave entry: Q30 Taylor series of sin, rounded to 15 bits
    function automatic logic [14:0] quarter_sine(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        int              n;
        x    = (64'(k) * HALF_PI_Q30) / ROM_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 8; n++)
        begin
            term = (term * x2) >> 30;
            term = term / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (unsigned'(sum) * PEAK + (64'd1 << 29)) >> 30;
        if (v > PEAK)
            v = PEAK;
        return v[14:0];
    endfunction

    // Scaled sine at a phase; odd quadrants mirror the table, their offset 0 is the peak
    function automatic int sine_value(logic [31:0] ph);
        logic [1:0]  quad;
        logic [9:0]  off;
        int unsigned t;
        int          mag;
        quad = ph[31:30];
        off  = ph[29:20];
        if (quad[0])
            t = (off == 0) ? PEAK : quarter_wave[ROM_DEPTH - int'(off)];
        else
            t = quarter_wave[off];
        mag = int'((32'(cfg_amp) * t) / PEAK);
        return quad[1] ? -mag : mag;
    endfunction

    // Top 16 phase bits as signed, scaled by amplitude, truncated toward zero
    function automatic int saw_value(logic [31:0] ph);
        int s;
        s = int'($signed(ph[31:16]));
        return (s * int'(cfg_amp)) / PEAK;
    endfunction

    // Advance the predictor by one tick and return the sample it emits
    function automatic logic signed [15:0] predict_sample(bit rs);
        int smp;
        int sn;
        int sw;
        int i;
        if (rs)
        begin
            osc_phase  = '0;
            noise_lfsr = (cfg_seed != 0) ? cfg_seed : mwo_pkg::NOISE_RESET;
        end
        for (i = 0; i < 16; i++)
        begin
            if (noise_lfsr[0])
                noise_lfsr = (noise_lfsr >> 1) ^ NOISE_TAPS;
            else
                noise_lfsr = noise_lfsr >> 1;
        end
        case (cfg_mode)
            mwo_pkg::MODE_SINE:     smp = sine_value(osc_phase);
            mwo_pkg::MODE_SQUARE:
                smp = (sine_value(osc_phase) > 0) ? int'(cfg_amp) : -int'(cfg_amp);
            mwo_pkg::MODE_TRIANGLE:
            begin
                sw = saw_value(osc_phase << 1);
                sn = sine_value(osc_phase);
                if ((sn < 0 && sw > 0) || (sn > 0 && sw < 0))
                    sw = -sw;
                if (sw > PEAK)
                    sw = PEAK;
                smp = sw;
            end
            mwo_pkg::MODE_SAWTOOTH: smp = saw_value(osc_phase);
            mwo_pkg::MODE_NOISE:    smp = int'(noise_lfsr[15:0]);
            default:                smp = 0;
        endcase
        osc_phase = osc_phase + cfg_step;
        return smp[15:0];
    endfunction

    // Offer one tick, with random idle cycles first, and record its expected sample
    task automatic send_tick(bit rs);
        while (src_idle_en && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do
            @(posedge clk);
        while (!in_ready);
        pending_samples.push_back(predict_sample(rs));
    endtask

    // Stop offering and wait until every expected sample has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // Register write; only called while the block is idle
    task automatic write_reg(mwo_pkg::cfg_index_t idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            mwo_pkg::CFG_MODE:       cfg_mode = val[2:0];
            mwo_pkg::CFG_PHASE_STEP: cfg_step = val;
            mwo_pkg::CFG_AMPLITUDE:  cfg_amp  = val[14:0];
            mwo_pkg::CFG_NOISE_SEED: cfg_seed = val;
            default:                 ;
        endcase
        @(posedge clk);
    endtask

    // A tick with the given restart flag followed by plain ticks, then drain
    task automatic run_burst(int n, bit restart_first);
        int i;
        send_tick(restart_first);
        for (i = 1; i < n; i++)
            send_tick(1'b0);
        wait_idle();
    endtask

    // Defaults after reset: sine at step 0 stays at zero
    task automatic test_reset_defaults();
        run_burst(2, 1'b0);
    endtask

    // Each waveform at quadrant boundaries, unused modes, zero seed, triangle saturation
    task automatic test_directed_waveforms();
        write_reg(mwo_pkg::CFG_PHASE_STEP, 32'h4000_0000);
        write_reg(mwo_pkg::CFG_AMPLITUDE, 32'd32767);
        write_reg(mwo_pkg::CFG_MODE, 32'(mwo_pkg::MODE_SINE));
        run_burst(4, 1'b1);
        write_reg(mwo_pkg::CFG_MODE, 32'(mwo_pkg::MODE_SQUARE));
        run_burst(2, 1'b1);
        // second tick doubles to the negative full scale, which negates past the top
        write_reg(mwo_pkg::CFG_MODE, 32'(mwo_pkg::MODE_TRIANGLE));
        run_burst(2, 1'b1);
        write_reg(mwo_pkg::CFG_PHASE_STEP, 32'h8000_0000);
        write_reg(mwo_pkg::CFG_MODE, 32'(mwo_pkg::MODE_SAWTOOTH));
        run_burst(2, 1'b1);
        // zero seed must load as one
        write_reg(mwo_pkg::CFG_NOISE_SEED, 32'h0000_0000);
        write_reg(mwo_pkg::CFG_MODE, 32'(mwo_pkg::MODE_NOISE));
        run_burst(2, 1'b1);
        write_reg(mwo_pkg::CFG_NOISE_SEED, 32'hFFFF_FFFF);
        run_burst(1, 1'b1);
        // codes past noise output silence
        write_reg(mwo_pkg::CFG_MODE, 32'd5);
        run_burst(1, 1'b0);
        write_reg(mwo_pkg::CFG_MODE, 32'd6);
        run_burst(1, 1'b0);
        write_reg(mwo_pkg::CFG_MODE, 32'd7);
        run_burst(1, 1'b0);
        write_reg(mwo_pkg::CFG_AMPLITUDE, 32'd0);
        write_reg(mwo_pkg::CFG_PHASE_STEP, 32'h0123_4567);
        write_reg(mwo_pkg::CFG_MODE, 32'(mwo_pkg::MODE_SINE));
        run_burst(2, 1'b1);
    endtask

    // Random register settings per phase, random ticks with occasional restarts
    task automatic test_random_settings();
        int          ph;
        int          i;
        logic [31:0] val;
        for (ph = 0; ph < 17; ph++)
        begin
            src_idle_en  = (ph % 3 != 0);
            sink_idle_en = (ph % 3 != 0);
            write_reg(mwo_pkg::CFG_MODE, (ph < 8) ? 32'(ph) : 32'($urandom_range(0, 7)));
            case ($urandom_range(0, 5))
                0:       val = 32'h0000_0000;
                1:       val = 32'h8000_0000;
                2:       val = 32'h0000_0001;
                3:       val = $urandom_range(1, 32'h00FF_FFFF);
                default: val = $urandom_range(0, 32'h8000_0000);
            endcase
            write_reg(mwo_pkg::CFG_PHASE_STEP, val);
            case ($urandom_range(0, 4))
                0:       val = 32'd0;
                1:       val = 32'd32767;
                2:       val = 32'd1;
                default: val = $urandom_range(0, 32767);
            endcase
            write_reg(mwo_pkg::CFG_AMPLITUDE, val);
            case ($urandom_range(0, 4))
                0:       val = 32'h0000_0000;
                1:       val = 32'h0000_0001;
                2:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            write_reg(mwo_pkg::CFG_NOISE_SEED, val);
            send_tick(1'b1);
            for (i = 1; i < 70; i++)
                send_tick($urandom_range(0, 99) < 4);
            wait_idle();
        end
    endtask

    // Receiver holds off for a long stretch while ticks keep coming
    task automatic test_output_stall();
        int i;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_reg(mwo_pkg::CFG_MODE, 32'(mwo_pkg::MODE_TRIANGLE));
        write_reg(mwo_pkg::CFG_PHASE_STEP, $urandom_range(1, 32'h8000_0000));
        stall_burst_id++;
        for (i = 0; i < 60; i++)
            send_tick(i == 0);
        wait_idle();
    endtask

    // Sample receiver: compare each accepted transaction, then drive out_ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatch_count++;
                $error("sample: no transaction expected, got %0d", sample);
            end
            else
            begin
                want_sample = pending_samples.pop_front();
                if (sample !== want_sample)
                begin
                    mismatch_count++;
                    $error("sample: expected %0d, got %0d", want_sample, sample);
                end
            end
        end
        if (stall_burst_id != burst_served)
        begin
            burst_served = stall_burst_id;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !(sink_idle_en && $urandom_range(0, 99) < 16);
    end

    // Main sequence
    initial
    begin
        for (int k = 0; k < ROM_DEPTH; k++)
            quarter_wave[k] = quarter_sine(k);
        cfg_mode   = 3'(mwo_pkg::MODE_SINE);
        cfg_step   = '0;
        cfg_amp    = mwo_pkg::A_PEAK;
        cfg_seed   = mwo_pkg::NOISE_RESET;
        osc_phase  = '0;
        noise_lfsr = mwo_pkg::NOISE_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_waveforms();
        test_random_settings();
        test_output_stall();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mwo_pkg.sv
rtl/mwo_phase_gen.sv
rtl/mwo_sine_rom.sv
rtl/mwo_shaper.sv
rtl/multi_waveform_oscillator.sv
sim/tb_multi_waveform_oscillator.sv
